@@ sv/bspk_pkg.sv @@
// types, constants and step programs for the b-spline kernel evaluator
`default_nettype none

package bspk_pkg;

   localparam int MAX_ORDER = 7;
   localparam int NSTEP = 7;
   localparam int QW = 37;
   localparam int MW = 2 * (QW - 1);

   typedef logic signed [QW-1:0] q_type;

   typedef enum logic [1:0] {
      CSR_SPLINE_ORDER  = 2'd0,
      CSR_INVERSE_SCALE = 2'd1,
      CSR_SHIFTED       = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      OP_ACC = 3'd0,
      OP_X   = 3'd1,
      OP_T   = 3'd2,
      OP_S   = 3'd3,
      OP_M   = 3'd4
   } opnd_type;

   typedef enum logic {
      AD_K = 1'b0,
      AD_T = 1'b1
   } add_type;

   typedef struct packed {
      opnd_type asel;
      opnd_type bsel;
      add_type  ad;
      logic     sv;
      q_type    m;
      q_type    k;
   } step_type;

   typedef struct packed {
      q_type off;
      logic  neg;
      logic  sh;
   } tcfg_type;

   typedef struct packed {
      logic [2:0] ord;
      logic [2:0] n;
      logic [2:0] p;
      logic       neg;
      logic       unsup;
      q_type      acc;
      q_type      s;
      q_type      x;
      q_type      t;
   } item_type;

   localparam q_type Q_ZERO  = '0;
   localparam q_type Q_ONE   = q_type'(64'd1 << 32);
   localparam q_type Q_HALF  = q_type'(64'd1 << 31);
   localparam q_type Q_TWO   = q_type'(64'd2 << 32);
   localparam q_type Q_THREE = q_type'(64'd3 << 32);
   localparam q_type Q_FOUR  = q_type'(64'd4 << 32);
   localparam q_type Q_3H    = q_type'(64'd3 << 31);
   localparam q_type Q_5H    = q_type'(64'd5 << 31);
   localparam q_type Q_7H    = q_type'(64'd7 << 31);

   localparam q_type K_3_4 = q_type'(((64'd3 << 32) + 64'd4 / 64'd2) / 64'd4);
   localparam q_type K_1_6 = q_type'(((64'd1 << 32) + 64'd6 / 64'd2) / 64'd6);
   localparam q_type K_5_6 = q_type'(((64'd5 << 32) + 64'd6 / 64'd2) / 64'd6);
   localparam q_type K_5_4 = q_type'(((64'd5 << 32) + 64'd4 / 64'd2) / 64'd4);
   localparam q_type K_5_24 = q_type'(((64'd5 << 32) + 64'd24 / 64'd2) / 64'd24);
   localparam q_type K_55_96 = q_type'(((64'd55 << 32) + 64'd96 / 64'd2) / 64'd96);
   localparam q_type K_115_192 = q_type'(((64'd115 << 32) + 64'd192 / 64'd2) / 64'd192);
   localparam q_type K_5_8 = q_type'(((64'd5 << 32) + 64'd8 / 64'd2) / 64'd8);
   localparam q_type K_1_4 = q_type'(((64'd1 << 32) + 64'd4 / 64'd2) / 64'd4);
   localparam q_type K_1_24 = q_type'(((64'd1 << 32) + 64'd24 / 64'd2) / 64'd24);
   localparam q_type K_1_12 = q_type'(((64'd1 << 32) + 64'd12 / 64'd2) / 64'd12);
   localparam q_type K_11_20 = q_type'(((64'd11 << 32) + 64'd20 / 64'd2) / 64'd20);
   localparam q_type K_3_8 = q_type'(((64'd3 << 32) + 64'd8 / 64'd2) / 64'd8);
   localparam q_type K_7_4 = q_type'(((64'd7 << 32) + 64'd4 / 64'd2) / 64'd4);
   localparam q_type K_17_40 = q_type'(((64'd17 << 32) + 64'd40 / 64'd2) / 64'd40);
   localparam q_type K_1_120 = q_type'(((64'd1 << 32) + 64'd120 / 64'd2) / 64'd120);
   localparam q_type K_7_48 = q_type'(((64'd7 << 32) + 64'd48 / 64'd2) / 64'd48);
   localparam q_type K_1_36 = q_type'(((64'd1 << 32) + 64'd36 / 64'd2) / 64'd36);
   localparam q_type K_77_192 = q_type'(((64'd77 << 32) + 64'd192 / 64'd2) / 64'd192);
   localparam q_type K_5887_11520 =
      q_type'(((64'd5887 << 32) + 64'd11520 / 64'd2) / 64'd11520);
   localparam q_type K_1_48 = q_type'(((64'd1 << 32) + 64'd48 / 64'd2) / 64'd48);
   localparam q_type K_21_64 = q_type'(((64'd21 << 32) + 64'd64 / 64'd2) / 64'd64);
   localparam q_type K_35_288 = q_type'(((64'd35 << 32) + 64'd288 / 64'd2) / 64'd288);
   localparam q_type K_91_256 = q_type'(((64'd91 << 32) + 64'd256 / 64'd2) / 64'd256);
   localparam q_type K_7_768 = q_type'(((64'd7 << 32) + 64'd768 / 64'd2) / 64'd768);
   localparam q_type K_7861_15360 =
      q_type'(((64'd7861 << 32) + 64'd15360 / 64'd2) / 64'd15360);
   localparam q_type K_7_60 = q_type'(((64'd7 << 32) + 64'd60 / 64'd2) / 64'd60);
   localparam q_type K_21_32 = q_type'(((64'd21 << 32) + 64'd32 / 64'd2) / 64'd32);
   localparam q_type K_133_72 = q_type'(((64'd133 << 32) + 64'd72 / 64'd2) / 64'd72);
   localparam q_type K_329_128 = q_type'(((64'd329 << 32) + 64'd128 / 64'd2) / 64'd128);
   localparam q_type K_1267_960 = q_type'(((64'd1267 << 32) + 64'd960 / 64'd2) / 64'd960);
   localparam q_type K_1379_7680 =
      q_type'(((64'd1379 << 32) + 64'd7680 / 64'd2) / 64'd7680);
   localparam q_type K_1_720 = q_type'(((64'd1 << 32) + 64'd720 / 64'd2) / 64'd720);
   localparam q_type K_1_144 = q_type'(((64'd1 << 32) + 64'd144 / 64'd2) / 64'd144);
   localparam q_type K_1_9 = q_type'(((64'd1 << 32) + 64'd9 / 64'd2) / 64'd9);
   localparam q_type K_1_3 = q_type'(((64'd1 << 32) + 64'd3 / 64'd2) / 64'd3);
   localparam q_type K_151_315 = q_type'(((64'd151 << 32) + 64'd315 / 64'd2) / 64'd315);
   localparam q_type K_1_240 = q_type'(((64'd1 << 32) + 64'd240 / 64'd2) / 64'd240);
   localparam q_type K_1_20 = q_type'(((64'd1 << 32) + 64'd20 / 64'd2) / 64'd20);
   localparam q_type K_7_30 = q_type'(((64'd7 << 32) + 64'd30 / 64'd2) / 64'd30);
   localparam q_type K_7_18 = q_type'(((64'd7 << 32) + 64'd18 / 64'd2) / 64'd18);
   localparam q_type K_1_10 = q_type'(((64'd1 << 32) + 64'd10 / 64'd2) / 64'd10);
   localparam q_type K_7_90 = q_type'(((64'd7 << 32) + 64'd90 / 64'd2) / 64'd90);
   localparam q_type K_103_210 = q_type'(((64'd103 << 32) + 64'd210 / 64'd2) / 64'd210);
   localparam q_type K_19_18 = q_type'(((64'd19 << 32) + 64'd18 / 64'd2) / 64'd18);
   localparam q_type K_49_18 = q_type'(((64'd49 << 32) + 64'd18 / 64'd2) / 64'd18);
   localparam q_type K_23_6 = q_type'(((64'd23 << 32) + 64'd6 / 64'd2) / 64'd6);
   localparam q_type K_217_90 = q_type'(((64'd217 << 32) + 64'd90 / 64'd2) / 64'd90);
   localparam q_type K_139_630 = q_type'(((64'd139 << 32) + 64'd630 / 64'd2) / 64'd630);
   localparam q_type K_1_5040 = q_type'(((64'd1 << 32) + 64'd5040 / 64'd2) / 64'd5040);

   // q.32 product, magnitude rounded half up, then signed
   function automatic q_type mq(input q_type a, input q_type b);
      logic [QW-2:0] ua;
      logic [QW-2:0] ub;
      logic [MW-1:0] pr;
      logic [MW-1:0] rr;
      q_type         r;
      ua = (QW-1)'(a[QW-1] ? -a : a);
      ub = (QW-1)'(b[QW-1] ? -b : b);
      pr = MW'(ua) * MW'(ub);
      rr = (pr + (MW'(1) << 31)) >> 32;
      r = q_type'(rr);
      return (a[QW-1] ^ b[QW-1]) ? -r : r;
   endfunction

   function automatic step_type mk(input opnd_type a, input opnd_type b, input q_type m,
                                   input q_type k, input logic sv = 1'b0,
                                   input add_type ad = AD_K);
      step_type st;
      st.asel = a;
      st.bsel = b;
      st.ad = ad;
      st.sv = sv;
      st.m = m;
      st.k = k;
      return st;
   endfunction

   function automatic q_type pick(input opnd_type sel, input item_type it, input q_type m);
      q_type v;
      case (sel)
         OP_ACC:  v = it.acc;
         OP_X:    v = it.x;
         OP_T:    v = it.t;
         OP_S:    v = it.s;
         OP_M:    v = m;
         default: v = m;
      endcase
      return v;
   endfunction

   function automatic tcfg_type t_setup(input logic [2:0] ord, input logic [2:0] n,
                                        input logic [2:0] p);
      tcfg_type tc;
      tc = '{off: Q_ZERO, neg: 1'b0, sh: 1'b0};
      case ({ord, n, p})
         {3'd2, 3'd0, 3'd1}: tc = '{off: Q_3H, neg: 1'b1, sh: 1'b0};
         {3'd3, 3'd0, 3'd0}: tc = '{off: -Q_TWO, neg: 1'b0, sh: 1'b0};
         {3'd3, 3'd0, 3'd1}: tc = '{off: Q_TWO, neg: 1'b1, sh: 1'b0};
         {3'd4, 3'd0, 3'd2}: tc = '{off: -Q_5H, neg: 1'b0, sh: 1'b0};
         {3'd5, 3'd0, 3'd2}: tc = '{off: Q_THREE, neg: 1'b1, sh: 1'b0};
         {3'd6, 3'd0, 3'd3}: tc = '{off: -Q_7H, neg: 1'b0, sh: 1'b0};
         {3'd7, 3'd0, 3'd3}: tc = '{off: Q_FOUR, neg: 1'b1, sh: 1'b0};
         {3'd2, 3'd1, 3'd1}: tc = '{off: -Q_3H, neg: 1'b0, sh: 1'b0};
         {3'd3, 3'd1, 3'd0}: tc = '{off: Q_ZERO, neg: 1'b1, sh: 1'b1};
         {3'd3, 3'd1, 3'd1}: tc = '{off: Q_TWO, neg: 1'b1, sh: 1'b0};
         default:            tc = '{off: Q_ZERO, neg: 1'b0, sh: 1'b0};
      endcase
      return tc;
   endfunction

   // step k of the program for one order, derivative and piece
   function automatic step_type prog_step(input logic [2:0] ord, input logic [2:0] n,
                                          input logic [2:0] p, input logic [2:0] k);
      step_type prg [NSTEP];
      for (int i = 0; i < NSTEP; i++) begin
         prg[i] = mk(OP_ACC, OP_M, Q_ONE, Q_ZERO);
      end
      case ({ord, n, p})
         {3'd0, 3'd0, 3'd0}: prg[0] = mk(OP_X, OP_M, Q_ZERO, Q_ONE);
         {3'd1, 3'd0, 3'd0}: prg[0] = mk(OP_X, OP_M, -Q_ONE, Q_ONE);
         {3'd2, 3'd0, 3'd0}: begin
            prg[0] = mk(OP_X, OP_X, Q_ZERO, Q_ZERO);
            prg[1] = mk(OP_ACC, OP_M, -Q_ONE, K_3_4);
         end
         {3'd2, 3'd0, 3'd1}: begin
            prg[0] = mk(OP_T, OP_T, Q_ZERO, Q_ZERO);
            prg[1] = mk(OP_ACC, OP_M, Q_HALF, Q_ZERO);
         end
         {3'd3, 3'd0, 3'd0}: begin
            prg[0] = mk(OP_X, OP_X, Q_ZERO, Q_ZERO);
            prg[1] = mk(OP_ACC, OP_T, Q_ZERO, Q_ZERO);
            prg[2] = mk(OP_ACC, OP_M, Q_THREE, Q_FOUR);
            prg[3] = mk(OP_ACC, OP_M, K_1_6, Q_ZERO);
         end
         {3'd3, 3'd0, 3'd1}: begin
            prg[0] = mk(OP_T, OP_T, Q_ZERO, Q_ZERO);
            prg[1] = mk(OP_ACC, OP_T, Q_ZERO, Q_ZERO);
            prg[2] = mk(OP_ACC, OP_M, K_1_6, Q_ZERO);
         end
         {3'd4, 3'd0, 3'd0}: begin
            prg[0] = mk(OP_X, OP_X, Q_ZERO, Q_ZERO, 1'b1);
            prg[1] = mk(OP_S, OP_M, K_1_4, -K_5_8);
            prg[2] = mk(OP_S, OP_ACC, Q_ZERO, K_115_192);
         end
         {3'd4, 3'd0, 3'd1}: begin
            prg[0] = mk(OP_X, OP_M, -K_1_6, K_5_6);
            prg[1] = mk(OP_X, OP_ACC, Q_ZERO, -K_5_4);
            prg[2] = mk(OP_X, OP_ACC, Q_ZERO, K_5_24);
            prg[3] = mk(OP_X, OP_ACC, Q_ZERO, K_55_96);
         end
         {3'd4, 3'd0, 3'd2}: begin
            prg[0] = mk(OP_T, OP_T, Q_ZERO, Q_ZERO);
            prg[1] = mk(OP_ACC, OP_ACC, Q_ZERO, Q_ZERO);
            prg[2] = mk(OP_ACC, OP_M, K_1_24, Q_ZERO);
         end
         {3'd5, 3'd0, 3'd0}: begin
            prg[0] = mk(OP_X, OP_X, Q_ZERO, Q_ZERO, 1'b1);
            prg[1] = mk(OP_X, OP_M, -K_1_12, K_1_4);
            prg[2] = mk(OP_S, OP_ACC, Q_ZERO, -Q_HALF);
            prg[3] = mk(OP_S, OP_ACC, Q_ZERO, K_11_20);
         end
         {3'd5, 3'd0, 3'd1}: begin
            prg[0] = mk(OP_X, OP_M, K_1_24, -K_3_8);
            prg[1] = mk(OP_X, OP_ACC, Q_ZERO, K_5_4);
            prg[2] = mk(OP_X, OP_ACC, Q_ZERO, -K_7_4);
            prg[3] = mk(OP_X, OP_ACC, Q_ZERO, K_5_8);
            prg[4] = mk(OP_X, OP_ACC, Q_ZERO, K_17_40);
         end
         {3'd5, 3'd0, 3'd2}: begin
            prg[0] = mk(OP_T, OP_T, Q_ZERO, Q_ZERO, 1'b1);
            prg[1] = mk(OP_T, OP_S, Q_ZERO, Q_ZERO);
            prg[2] = mk(OP_ACC, OP_S, Q_ZERO, Q_ZERO);
            prg[3] = mk(OP_ACC, OP_M, K_1_120, Q_ZERO);
         end
         {3'd6, 3'd0, 3'd0}: begin
            prg[0] = mk(OP_X, OP_X, Q_ZERO, Q_ZERO, 1'b1);
            prg[1] = mk(OP_S, OP_M, -K_1_36, K_7_48);
            prg[2] = mk(OP_S, OP_ACC, Q_ZERO, -K_77_192);
            prg[3] = mk(OP_S, OP_ACC, Q_ZERO, K_5887_11520);
         end
         {3'd6, 3'd0, 3'd1}: begin
            prg[0] = mk(OP_X, OP_M, K_1_48, -K_7_48);
            prg[1] = mk(OP_X, OP_ACC, Q_ZERO, K_21_64);
            prg[2] = mk(OP_X, OP_ACC, Q_ZERO, -K_35_288);
            prg[3] = mk(OP_X, OP_ACC, Q_ZERO, -K_91_256);
            prg[4] = mk(OP_X, OP_ACC, Q_ZERO, -K_7_768);
            prg[5] = mk(OP_X, OP_ACC, Q_ZERO, K_7861_15360);
         end
         {3'd6, 3'd0, 3'd2}: begin
            prg[0] = mk(OP_X, OP_M, -K_1_120, K_7_60);
            prg[1] = mk(OP_X, OP_ACC, Q_ZERO, -K_21_32);
            prg[2] = mk(OP_X, OP_ACC, Q_ZERO, K_133_72);
            prg[3] = mk(OP_X, OP_ACC, Q_ZERO, -K_329_128);
            prg[4] = mk(OP_X, OP_ACC, Q_ZERO, K_1267_960);
            prg[5] = mk(OP_X, OP_ACC, Q_ZERO, K_1379_7680);
         end
         {3'd6, 3'd0, 3'd3}: begin
            prg[0] = mk(OP_T, OP_T, Q_ZERO, Q_ZERO);
            prg[1] = mk(OP_ACC, OP_T, Q_ZERO, Q_ZERO);
            prg[2] = mk(OP_ACC, OP_ACC, Q_ZERO, Q_ZERO);
            prg[3] = mk(OP_ACC, OP_M, K_1_720, Q_ZERO);
         end
         {3'd7, 3'd0, 3'd0}: begin
            prg[0] = mk(OP_X, OP_X, Q_ZERO, Q_ZERO, 1'b1);
            prg[1] = mk(OP_X, OP_M, K_1_144, -K_1_36);
            prg[2] = mk(OP_S, OP_ACC, Q_ZERO, K_1_9);
            prg[3] = mk(OP_S, OP_ACC, Q_ZERO, -K_1_3);
            prg[4] = mk(OP_S, OP_ACC, Q_ZERO, K_151_315);
         end
         {3'd7, 3'd0, 3'd1}: begin
            prg[0] = mk(OP_X, OP_M, -K_1_240, K_1_20);
            prg[1] = mk(OP_X, OP_ACC, Q_ZERO, -K_7_30);
            prg[2] = mk(OP_X, OP_ACC, Q_ZERO, Q_HALF);
            prg[3] = mk(OP_X, OP_ACC, Q_ZERO, -K_7_18);
            prg[4] = mk(OP_X, OP_ACC, Q_ZERO, -K_1_10);
            prg[5] = mk(OP_X, OP_ACC, Q_ZERO, -K_7_90);
            prg[6] = mk(OP_X, OP_ACC, Q_ZERO, K_103_210);
         end
         {3'd7, 3'd0, 3'd2}: begin
            prg[0] = mk(OP_X, OP_M, K_1_720, -K_1_36);
            prg[1] = mk(OP_X, OP_ACC, Q_ZERO, K_7_30);
            prg[2] = mk(OP_X, OP_ACC, Q_ZERO, -K_19_18);
            prg[3] = mk(OP_X, OP_ACC, Q_ZERO, K_49_18);
            prg[4] = mk(OP_X, OP_ACC, Q_ZERO, -K_23_6);
            prg[5] = mk(OP_X, OP_ACC, Q_ZERO, K_217_90);
            prg[6] = mk(OP_X, OP_ACC, Q_ZERO, -K_139_630);
         end
         {3'd7, 3'd0, 3'd3}: begin
            prg[0] = mk(OP_T, OP_T, Q_ZERO, Q_ZERO);
            prg[1] = mk(OP_ACC, OP_T, Q_ZERO, Q_ZERO);
            prg[2] = mk(OP_ACC, OP_ACC, Q_ZERO, Q_ZERO);
            prg[3] = mk(OP_ACC, OP_T, Q_ZERO, Q_ZERO);
            prg[4] = mk(OP_ACC, OP_M, K_1_5040, Q_ZERO);
         end
         {3'd1, 3'd1, 3'd0}: prg[0] = mk(OP_X, OP_M, Q_ZERO, -Q_ONE);
         {3'd2, 3'd1, 3'd0}: prg[0] = mk(OP_X, OP_M, -Q_TWO, Q_ZERO);
         {3'd2, 3'd1, 3'd1}: prg[0] = mk(OP_T, OP_M, Q_ONE, Q_ZERO);
         {3'd2, 3'd2, 3'd0}: prg[0] = mk(OP_X, OP_M, Q_ZERO, -Q_TWO);
         {3'd2, 3'd2, 3'd1}: prg[0] = mk(OP_X, OP_M, Q_ZERO, Q_ONE);
         {3'd3, 3'd1, 3'd0}: begin
            prg[0] = mk(OP_X, OP_X, Q_ZERO, Q_ZERO);
            prg[1] = mk(OP_ACC, OP_M, Q_3H, Q_ZERO, 1'b0, AD_T);
         end
         {3'd3, 3'd1, 3'd1}: begin
            prg[0] = mk(OP_T, OP_T, Q_ZERO, Q_ZERO);
            prg[1] = mk(OP_ACC, OP_M, -Q_HALF, Q_ZERO);
         end
         {3'd3, 3'd2, 3'd0}: prg[0] = mk(OP_X, OP_M, Q_THREE, -Q_TWO);
         {3'd3, 3'd2, 3'd1}: prg[0] = mk(OP_X, OP_M, -Q_ONE, Q_TWO);
         {3'd3, 3'd3, 3'd0}: prg[0] = mk(OP_X, OP_M, Q_ZERO, Q_THREE);
         {3'd3, 3'd3, 3'd1}: prg[0] = mk(OP_X, OP_M, Q_ZERO, -Q_ONE);
         default: prg[0] = mk(OP_ACC, OP_M, Q_ONE, Q_ZERO);
      endcase
      return prg[k];
   endfunction

endpackage

`default_nettype wire

@@ sv/bspline_kernel_eval.sv @@
// centered b-spline kernel evaluator, orders 0 to 7, pipelined
//
//  channel | ports                                   | direction
//  req     | req_valid req_stall req_position        | in
//          | req_derivative_order                    |
//  rsp     | rsp_valid rsp_stall rsp_kernel_value    | out
//          | rsp_unsupported                         |
//  csr     | csr_write csr_index csr_data            | in
//
// one word per cycle unless rsp_stall backs up the pipe; a word passes the input, clamp
// and piece registers and seven multiply-add stages that run each piece's polynomial
// a stalled rsp holds the output register; bubbles in the pipe still fill up
// reset empties the pipe and loads order 3, unit scale, centered
`default_nettype none

module bspline_kernel_eval (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_position,
   input  wire logic [2:0]  req_derivative_order,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_kernel_value,
   output logic             rsp_unsupported,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int NS = bspk_pkg::NSTEP;
   localparam int QW = bspk_pkg::QW;

   logic [2:0]  spline_order_ff;
   logic [31:0] inverse_scale_ff;
   logic        shifted_ff;

   logic        v1_ff;
   logic [63:0] prod_ff;
   logic [63:0] prod_in;
   logic [2:0]  n1_ff;

   logic              v2_ff;
   bspk_pkg::q_type   x2_ff;
   bspk_pkg::q_type   x2_in;
   logic              neg2_ff;
   logic              neg2_in;
   logic [2:0]        n2_ff;
   logic [63:0]       sp;
   logic [63:0]       mag;

   logic [NS:0]        vs_ff;
   logic [NS:0]        en_st;
   bspk_pkg::item_type st_ff [NS+1];
   bspk_pkg::item_type st_in [NS+1];

   logic              en1;
   logic              en2;
   logic              en_out;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_kernel_value_ff;
   logic [31:0]       rsp_kernel_value_in;
   logic              rsp_unsupported_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         spline_order_ff <= 3'd3;
         inverse_scale_ff <= 32'd65536;
         shifted_ff <= 1'b0;
      end else if (csr_write) begin
         case (bspk_pkg::csr_type'(csr_index))
            bspk_pkg::CSR_SPLINE_ORDER:  spline_order_ff <= csr_data[2:0];
            bspk_pkg::CSR_INVERSE_SCALE: inverse_scale_ff <= csr_data;
            bspk_pkg::CSR_SHIFTED:       shifted_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // handshake chain, back to front
   always_comb begin
      en_out = !rsp_valid_ff || !rsp_stall;
      en_st[NS] = !vs_ff[NS] || en_out;
      for (int i = NS - 1; i >= 0; i--) begin
         en_st[i] = !vs_ff[i] || en_st[i+1];
      end
      en2 = !v2_ff || en_st[0];
      en1 = !v1_ff || en2;
   end

   assign req_stall = !en1;

   // scale the position
   assign prod_in = 64'(signed'(req_position)) * 64'(signed'({1'b0, inverse_scale_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         prod_ff <= prod_in;
         n1_ff <= req_derivative_order;
      end
   end

   // shift, magnitude, clamp
   always_comb begin
      sp = prod_ff + (shifted_ff ? (64'd1 << 31) : 64'd0);
      neg2_in = sp[63];
      mag = neg2_in ? -sp : sp;
      if (mag > (64'd4 << 32)) begin
         x2_in = bspk_pkg::Q_FOUR;
      end else begin
         x2_in = QW'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         x2_ff <= x2_in;
         neg2_ff <= neg2_in;
         n2_ff <= n1_ff;
      end
   end

   // piece, offset variable and support check
   always_comb begin
      logic [QW-1:0]      ps;
      logic [2:0]         pc;
      bspk_pkg::tcfg_type tc;
      bspk_pkg::q_type    xs;
      logic               ok;
      ps = spline_order_ff[0] ? x2_ff : x2_ff + bspk_pkg::Q_HALF;
      pc = ps[34:32];
      tc = bspk_pkg::t_setup(spline_order_ff, n2_ff, pc);
      xs = tc.sh ? (x2_ff <<< 1) : x2_ff;
      ok = (n2_ff == 3'd0)
         || (spline_order_ff == 3'd1 && n2_ff == 3'd1)
         || (spline_order_ff == 3'd2 && (n2_ff == 3'd1 || n2_ff == 3'd2))
         || (spline_order_ff == 3'd3 && n2_ff <= 3'd3);
      if (32'(spline_order_ff) > bspk_pkg::MAX_ORDER) begin
         ok = 1'b0;
      end
      st_in[0].ord = spline_order_ff;
      st_in[0].n = n2_ff;
      st_in[0].p = pc;
      st_in[0].neg = neg2_ff;
      st_in[0].unsup = !ok;
      st_in[0].acc = '0;
      st_in[0].s = '0;
      st_in[0].x = x2_ff;
      st_in[0].t = tc.off + (tc.neg ? -xs : xs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff[0] <= 1'b0;
      end else if (en_st[0]) begin
         vs_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_st[0]) begin
         st_ff[0] <= st_in[0];
      end
   end

   // multiply-add stages
   for (genvar k = 0; k < NS; k++) begin : g_step
      always_comb begin
         bspk_pkg::step_type sc;
         bspk_pkg::q_type    a;
         bspk_pkg::q_type    b;
         bspk_pkg::q_type    r;
         sc = bspk_pkg::prog_step(st_ff[k].ord, st_ff[k].n, st_ff[k].p, 3'(k));
         a = bspk_pkg::pick(sc.asel, st_ff[k], sc.m);
         b = bspk_pkg::pick(sc.bsel, st_ff[k], sc.m);
         r = bspk_pkg::mq(a, b) + ((sc.ad == bspk_pkg::AD_T) ? st_ff[k].t : sc.k);
         st_in[k+1] = st_ff[k];
         st_in[k+1].acc = r;
         if (sc.sv) begin
            st_in[k+1].s = r;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[k+1] <= 1'b0;
         end else if (en_st[k+1]) begin
            vs_ff[k+1] <= vs_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en_st[k+1]) begin
            st_ff[k+1] <= st_in[k+1];
         end
      end
   end

   // sign, rounding to q3.28, saturation
   always_comb begin
      bspk_pkg::q_type r;
      logic            flip;
      logic            rn;
      logic [QW-2:0]   am;
      logic [QW-1:0]   rs;
      logic [32:0]     m;
      flip = st_ff[NS].neg && st_ff[NS].n[0] && !st_ff[NS].unsup;
      r = st_ff[NS].unsup ? '0 : (flip ? -st_ff[NS].acc : st_ff[NS].acc);
      rn = r[QW-1];
      am = (QW-1)'(rn ? -r : r);
      rs = {1'b0, am} + QW'(8);
      m = 33'(rs >> 4);
      if (rn) begin
         if (m > 33'h0_8000_0000) begin
            rsp_kernel_value_in = 32'h8000_0000;
         end else begin
            rsp_kernel_value_in = 32'(-m);
         end
      end else begin
         if (m > 33'h0_7FFF_FFFF) begin
            rsp_kernel_value_in = 32'h7FFF_FFFF;
         end else begin
            rsp_kernel_value_in = m[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= vs_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_kernel_value_ff <= rsp_kernel_value_in;
         rsp_unsupported_ff <= st_ff[NS].unsup;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kernel_value = rsp_kernel_value_ff;
   assign rsp_unsupported = rsp_unsupported_ff;

   a_unsup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unsupported |-> rsp_kernel_value == 32'd0)
      else $error("unsupported word with nonzero value");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (x2_ff <= bspk_pkg::Q_FOUR) && !x2_ff[QW-1])
      else $error("position magnitude out of range");

   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v1_ff)
      else $error("taken word lost at first stage");

endmodule

`default_nettype wire

@@ sim/bspline_kernel_eval_test.sv @@
// self-checking testbench for the b-spline kernel evaluator against a local predictor
`default_nettype none

module bspline_kernel_eval_test;

   localparam longint Q1 = 64'sd1 <<< 32;
   localparam longint QH = 64'sd1 <<< 31;
   localparam int WATCH_LIMIT = 4000;

   typedef struct {
      logic [31:0] position;
      logic [2:0]  deriv;
   } word_type;

   typedef struct {
      logic [31:0] value;
      logic        unsup;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_position = '0;
   logic [2:0]  req_derivative_order = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_kernel_value;
   logic        rsp_unsupported;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   word_type   pending_words[$];
   result_type expected_results[$];
   logic [2:0]  cur_order;
   logic [31:0] cur_inv_scale;
   logic        cur_shifted;
   bit          failed = 1'b0;
   bit          quiet_end = 1'b0;
   bit          req_taken = 1'b0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int          idle_cycles = 0;

   bspline_kernel_eval u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_position(req_position), .req_derivative_order(req_derivative_order),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kernel_value(rsp_kernel_value), .rsp_unsupported(rsp_unsupported),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint frac_q(longint num, longint den);
      return ((num <<< 32) + den / 2) / den;
   endfunction

   // q.32 product, magnitude rounded half up
   function automatic longint qmul(longint a, longint b);
      logic [127:0] ua;
      logic [127:0] ub;
      logic [127:0] pr;
      longint       r;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      pr = (ua * ub + (128'd1 << 31)) >> 32;
      r = pr > 128'h7FFFFFFFFFFFFFFF ? 64'sh7FFFFFFFFFFFFFFF : longint'(pr[63:0]);
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   function automatic longint horner(longint x, longint c[]);
      longint a;
      a = c[0];
      for (int i = 1; i < c.size(); i++) a = qmul(x, a) + c[i];
      return a;
   endfunction

   function automatic longint kernel_q(int ord, longint x);
      longint a, s, t, c;
      case (ord)
         0: return x < QH ? Q1 : 0;
         1: return x < Q1 ? Q1 - x : 0;
         2: begin
            if (x < QH) return frac_q(3, 4) - qmul(x, x);
            if (x < 3 * QH) begin
               t = 3 * QH - x;
               return qmul(qmul(t, t), QH);
            end
            return 0;
         end
         3: begin
            if (x < Q1) begin
               a = qmul(qmul(x, x), x - 2 * Q1);
               return qmul(3 * a + 4 * Q1, frac_q(1, 6));
            end
            if (x < 2 * Q1) begin
               t = 2 * Q1 - x;
               return qmul(qmul(qmul(t, t), t), frac_q(1, 6));
            end
            return 0;
         end
         4: begin
            if (x < QH) begin
               s = qmul(x, x);
               return qmul(s, qmul(s, frac_q(1, 4)) - frac_q(5, 8)) + frac_q(115, 192);
            end
            if (x < 3 * QH) begin
               a = frac_q(5, 6) - qmul(x, frac_q(1, 6));
               return horner(x, '{a, -frac_q(5, 4), frac_q(5, 24), frac_q(55, 96)});
            end
            if (x < 5 * QH) begin
               t = x - 5 * QH;
               s = qmul(t, t);
               return qmul(qmul(s, s), frac_q(1, 24));
            end
            return 0;
         end
         5: begin
            if (x < Q1) begin
               s = qmul(x, x);
               a = frac_q(1, 4) - qmul(x, frac_q(1, 12));
               a = qmul(s, a) - QH;
               return qmul(s, a) + frac_q(11, 20);
            end
            if (x < 2 * Q1) begin
               a = qmul(x, frac_q(1, 24)) - frac_q(3, 8);
               return horner(x, '{a, frac_q(5, 4), -frac_q(7, 4), frac_q(5, 8),
                                  frac_q(17, 40)});
            end
            if (x < 3 * Q1) begin
               t = 3 * Q1 - x;
               s = qmul(t, t);
               return qmul(qmul(qmul(t, s), s), frac_q(1, 120));
            end
            return 0;
         end
         6: begin
            if (x < QH) begin
               s = qmul(x, x);
               a = frac_q(7, 48) - qmul(s, frac_q(1, 36));
               a = qmul(s, a) - frac_q(77, 192);
               return qmul(s, a) + frac_q(5887, 11520);
            end
            if (x < 3 * QH) begin
               a = qmul(x, frac_q(1, 48)) - frac_q(7, 48);
               return horner(x, '{a, frac_q(21, 64), -frac_q(35, 288), -frac_q(91, 256),
                                  -frac_q(7, 768), frac_q(7861, 15360)});
            end
            if (x < 5 * QH) begin
               a = frac_q(7, 60) - qmul(x, frac_q(1, 120));
               return horner(x, '{a, -frac_q(21, 32), frac_q(133, 72), -frac_q(329, 128),
                                  frac_q(1267, 960), frac_q(1379, 7680)});
            end
            if (x < 7 * QH) begin
               t = x - 7 * QH;
               c = qmul(qmul(t, t), t);
               return qmul(qmul(c, c), frac_q(1, 720));
            end
            return 0;
         end
         default: begin
            if (x < Q1) begin
               s = qmul(x, x);
               a = qmul(x, frac_q(1, 144)) - frac_q(1, 36);
               a = qmul(s, a) + frac_q(1, 9);
               a = qmul(s, a) - frac_q(1, 3);
               return qmul(s, a) + frac_q(151, 315);
            end
            if (x < 2 * Q1) begin
               a = frac_q(1, 20) - qmul(x, frac_q(1, 240));
               return horner(x, '{a, -frac_q(7, 30), QH, -frac_q(7, 18), -frac_q(1, 10),
                                  -frac_q(7, 90), frac_q(103, 210)});
            end
            if (x < 3 * Q1) begin
               a = qmul(x, frac_q(1, 720)) - frac_q(1, 36);
               return horner(x, '{a, frac_q(7, 30), -frac_q(19, 18), frac_q(49, 18),
                                  -frac_q(23, 6), frac_q(217, 90), -frac_q(139, 630)});
            end
            if (x < 4 * Q1) begin
               t = 4 * Q1 - x;
               c = qmul(qmul(t, t), t);
               return qmul(qmul(qmul(c, c), t), frac_q(1, 5040));
            end
            return 0;
         end
      endcase
   endfunction

   function automatic result_type predict_kernel(word_type w);
      result_type   res;
      longint       sp, x, r, t;
      logic [63:0]  mag;
      logic [63:0]  m;
      bit           neg, ok;
      int           n;
      n = w.deriv;
      sp = longint'($signed(w.position)) * longint'({32'd0, cur_inv_scale})
           + (cur_shifted ? QH : 0);
      neg = sp < 0;
      mag = neg ? -sp : sp;
      if (mag > 4 * Q1) mag = 4 * Q1;
      x = mag;
      ok = 1'b1;
      r = 0;
      if (n == 0) r = kernel_q(cur_order, x);
      else if (cur_order == 1 && n == 1) r = x < Q1 ? -Q1 : 0;
      else if (cur_order == 2 && n == 1)
         r = x < QH ? -2 * x : (x < 3 * QH ? x - 3 * QH : 0);
      else if (cur_order == 2 && n == 2) r = x < QH ? -2 * Q1 : (x < 3 * QH ? Q1 : 0);
      else if (cur_order == 3 && n == 1) begin
         if (x < Q1) r = qmul(3 * QH, qmul(x, x)) - 2 * x;
         else if (x < 2 * Q1) begin
            t = 2 * Q1 - x;
            r = -qmul(QH, qmul(t, t));
         end
      end
      else if (cur_order == 3 && n == 2)
         r = x < Q1 ? 3 * x - 2 * Q1 : (x < 2 * Q1 ? 2 * Q1 - x : 0);
      else if (cur_order == 3 && n == 3) r = x < Q1 ? 3 * Q1 : (x < 2 * Q1 ? -Q1 : 0);
      else ok = 1'b0;
      if (ok && neg && n[0]) r = -r;
      if (!ok) r = 0;
      m = r < 0 ? -r : r;
      m = (m + 8) >> 4;
      if (r < 0) res.value = m > 64'h80000000 ? 32'h80000000 : -m[31:0];
      else res.value = m > 64'h7FFFFFFF ? 32'h7FFFFFFF : m[31:0];
      res.unsup = !ok;
      return res;
   endfunction

   // monitor
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected word value=%h unsup=%b", $time,
                     rsp_kernel_value, rsp_unsupported);
            failed = 1'b1;
         end else begin
            result_type e;
            e = expected_results.pop_front();
            if (e.value !== rsp_kernel_value) begin
               $display("%0t: kernel_value expected %h actual %h", $time, e.value,
                        rsp_kernel_value);
               failed = 1'b1;
            end
            if (e.unsup !== rsp_unsupported) begin
               $display("%0t: unsupported expected %b actual %b", $time, e.unsup,
                        rsp_unsupported);
               failed = 1'b1;
            end
         end
      end
      if (!reset && req_valid && !req_stall)
         expected_results.push_back(predict_kernel(pending_words[0]));
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("bspline_kernel_eval: mismatch");
         $finish;
      end
   end

   // driver
   always @(negedge clock) begin
      if (req_taken) void'(pending_words.pop_front());
      if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken) && !quiet_end && $urandom_range(0, 9) == 0) begin
         send_gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
         req_valid <= 1'b1;
         req_position <= pending_words[0].position;
         req_derivative_order <= pending_words[0].deriv;
      end else begin
         req_valid <= 1'b0;
      end
      if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else if (!quiet_end && $urandom_range(0, 9) == 0) begin
         recv_gap = $urandom_range(1, 12);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(bspk_pkg::csr_type idx, logic [31:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         bspk_pkg::CSR_SPLINE_ORDER:  cur_order = data[2:0];
         bspk_pkg::CSR_INVERSE_SCALE: cur_inv_scale = data;
         bspk_pkg::CSR_SHIFTED:       cur_shifted = data[0];
         default: ;
      endcase
   endtask

   task automatic drain_words();
      while (pending_words.size() > 0 || expected_results.size() > 0 || req_valid)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic queue_word(logic [31:0] p, logic [2:0] d);
      word_type w;
      w.position = p;
      w.deriv = d;
      pending_words.push_back(w);
   endtask

   function automatic logic [31:0] random_position();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return {{14{1'b0}}, 18'($urandom)} ^ ($urandom_range(0, 1) ? 32'hFFFFFFFF : 0);
         default: return $urandom_range(0, 32'h00090000) - 32'h00048000;
      endcase
   endfunction

   initial begin
      logic [31:0] scale_set[6];
      cur_order = 3'd3;
      cur_inv_scale = 32'h00010000;
      cur_shifted = 1'b0;
      scale_set = '{32'h00010000, 32'h00000001, 32'hFFFFFFFF, 32'h00008000,
                    32'h00020000, 32'h0001_8000};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, piece edges, every derivative, order 3 reset setting
      for (int d = 0; d < 8; d++) queue_word(32'h0000_8000, d[2:0]);
      queue_word(32'h8000_0000, 3'd1);
      queue_word(32'h7FFF_FFFF, 3'd0);
      queue_word(32'h0000_0000, 3'd1);
      queue_word(32'h0000_0000, 3'd3);
      queue_word(32'hFFFF_0000, 3'd1);
      queue_word(32'h0001_0000, 3'd2);
      queue_word(32'h0002_0000, 3'd0);
      queue_word(32'hFFFE_0000, 3'd3);
      queue_word(32'h0003_FFFF, 3'd0);
      queue_word(32'h0004_0000, 3'd0);
      queue_word(32'hFFFF_FFFF, 3'd7);
      drain_words();
      write_reg(bspk_pkg::CSR_INVERSE_SCALE, 32'd0);
      write_reg(bspk_pkg::CSR_SHIFTED, 32'd1);
      queue_word(32'h1234_5678, 3'd0);
      queue_word(32'h0000_0000, 3'd2);
      drain_words();

      for (int phase = 0; phase < 26; phase++) begin
         if (phase >= 22) quiet_end = 1'b1;
         write_reg(bspk_pkg::CSR_SPLINE_ORDER, phase < 8 ? phase : $urandom_range(0, 7));
         write_reg(bspk_pkg::CSR_INVERSE_SCALE, phase < 6 ? scale_set[phase]
                   : ($urandom_range(0, 3) == 0 ? $urandom | 1 : $urandom_range(1, 32'h30000)));
         write_reg(bspk_pkg::CSR_SHIFTED, $urandom_range(0, 1));
         for (int i = 0; i < 25; i++)
            queue_word(random_position(),
                       $urandom_range(0, 2) == 0 ? 3'($urandom) : 3'($urandom_range(0, 3)));
         drain_words();
      end

      if (!failed)
         $display("bspline_kernel_eval: match");
      else
         $display("bspline_kernel_eval: mismatch");
      $finish;
   end
endmodule

`default_nettype wire
